// ===== rtl/core/ccse_pkg.sv =====
package ccse_pkg;

	// Field widths
	localparam int unsigned CUR_W   = 32;
	localparam int unsigned CELL_W  = 16;
	localparam int unsigned TEMP_W  = 8;
	localparam int unsigned RUN_W   = 16;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned CAP_W   = 32;
	localparam int unsigned FULL_W  = 19;
	localparam int unsigned CYC_W   = 16;
	localparam int unsigned SAMP_W  = 8;
	localparam int unsigned DIV_W   = 32;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY_LIMIT  = 1'b0,
		CFG_CYCLE_THRESHOLD = 1'b1
	} cfg_idx_t;

	// Constants of the algorithm
	localparam logic [CAP_W-1:0]  CAP_LIMIT_RST   = 32'd139680000;
	localparam logic [CAP_W-1:0]  CYC_THR_RST     = 32'd139680000;
	localparam logic [FULL_W-1:0] NOMINAL_FULL    = 19'h025E4;
	localparam logic [CAP_W-1:0]  CAP_SCALE       = 32'h00003840;
	localparam logic [CAP_W-1:0]  SMALL_CURRENT   = 32'd199;
	localparam logic [CELL_W-1:0] CELL_LOW        = 16'h0C4E;
	localparam logic [CELL_W-1:0] CELL_MID        = 16'h0D01;
	localparam logic [RUN_W-1:0]  LEARN_RUN       = 16'h9E33;
	localparam logic [CAP_W-1:0]  LEARN_CURRENT   = 32'h0000014B;
	localparam logic [SAMP_W-1:0] LEARN_COUNT     = 8'hEF;
	localparam logic [TEMP_W-1:0] TEMP_COLD       = 8'h3A;
	localparam logic [PCT_W-1:0]  PCT_FULL        = 7'd100;
	localparam logic [PCT_W-1:0]  PCT_TIER        = 7'd7;

	// Divide by CAP_SCALE: 14400 = 225 * 64, so drop six bits, then multiply
	// by ceil(2^34 / 225); exact for every 26-bit value left
	localparam int unsigned SCALE_PRE     = 6;
	localparam int unsigned SCALE_SHIFT   = 34;
	localparam int unsigned SCALE_RECIP_W = 27;
	localparam int unsigned SCALE_PROD_W  = CAP_W - SCALE_PRE + SCALE_RECIP_W;
	localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 27'd76354975;

endpackage

// ===== rtl/core/ccse_in_if.sv =====
interface ccse_in_if
	import ccse_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [CUR_W-1:0]  current_sample;
	logic        [CELL_W-1:0] min_cell_level;
	logic        [TEMP_W-1:0] temp_first;
	logic        [TEMP_W-1:0] temp_second;
	logic        [RUN_W-1:0]  run_time;

	modport source (output valid, current_sample, min_cell_level, temp_first,
		temp_second, run_time, input ready);
	modport sink (input valid, current_sample, min_cell_level, temp_first,
		temp_second, run_time, output ready);
endinterface

// ===== rtl/core/ccse_out_if.sv =====
interface ccse_out_if
	import ccse_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [PCT_W-1:0]  charge_percent;
	logic [PCT_W-1:0]  derated_percent;
	logic [CAP_W-1:0]  remaining_out;
	logic [CAP_W-1:0]  accumulator_out;
	logic [FULL_W-1:0] full_capacity_out;
	logic [CYC_W-1:0]  cycles_out;

	modport source (output valid, charge_percent, derated_percent, remaining_out,
		accumulator_out, full_capacity_out, cycles_out, input ready);
	modport sink (input valid, charge_percent, derated_percent, remaining_out,
		accumulator_out, full_capacity_out, cycles_out, output ready);
endinterface

// ===== rtl/core/ccse_div.sv =====
module ccse_div
	import ccse_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       trial;
	logic                 fits;

	// One quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_W'(trial - {1'b0, dvs_q}) : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/coulomb_counter_soc_estimator_core.sv =====
// Coulomb counter with state-of-charge estimation. One current sample is taken
// when sample.ready is high, which is only while the block is idle. A discharge
// sample makes one to three tiered remaining-capacity subtractions and one more
// when the accumulator is below the remaining capacity; a charge sample may
// update the full capacity; a zero full capacity skips the percent divide. A
// shared 32-bit restoring divider (one quotient bit per cycle) is used for the
// charge percent and, after a full-capacity update, the derated percent; the
// divides by the fixed capacity scale use a reciprocal multiply. A finished
// result waits in an output register, so the next sample can be taken while the
// previous result is still unread; a second result waits in the block until the
// first is taken. Configuration writes go straight to their registers and should
// be made while the block is idle.
module coulomb_counter_soc_estimator_core
	import ccse_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_wdata,
	ccse_in_if.sink              sample,
	ccse_out_if.source           result
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIS_ACC,
		S_DIS_REM,
		S_DIS_EXTRA,
		S_CHG_ADD,
		S_CHG_LEARN,
		S_LRN_SUM,
		S_FULL_CHECK,
		S_DER_START,
		S_DER_WAIT,
		S_CLAMP,
		S_SCALE,
		S_SOC_START,
		S_SOC_WAIT,
		S_FINISH
	} state_t;

	state_t state_q;

	// Configuration
	logic [CAP_W-1:0] cap_limit_q;
	logic [CAP_W-1:0] cyc_thr_q;

	// Estimator state
	logic [CAP_W-1:0]  acc_q;
	logic [CAP_W-1:0]  rem_q;
	logic [FULL_W-1:0] full_q;
	logic [CAP_W-1:0]  cyc_acc_q;
	logic [CYC_W-1:0]  cyc_cnt_q;
	logic [PCT_W-1:0]  soc_q;
	logic [PCT_W-1:0]  der_q;
	logic [CAP_W-1:0]  lstart_q;
	logic [CAP_W-1:0]  lsum_q;
	logic [SAMP_W-1:0] lsamp_q;

	// Latched request
	logic [CAP_W-1:0]  cur_q;
	logic [CAP_W-1:0]  mag_q;
	logic [CELL_W-1:0] cell_q;
	logic [TEMP_W-1:0] t1_q;
	logic [TEMP_W-1:0] t2_q;
	logic [RUN_W-1:0]  run_q;
	logic [1:0]        cnt_q;
	logic [FULL_W-1:0] scr_q;

	// Divider handshake
	logic             div_start;
	logic             div_start_q;
	logic [DIV_W-1:0] div_dividend_q;
	logic [DIV_W-1:0] div_divisor_q;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	// Output register
	logic              out_valid_q;
	logic [PCT_W-1:0]  o_soc_q;
	logic [PCT_W-1:0]  o_der_q;
	logic [CAP_W-1:0]  o_rem_q;
	logic [CAP_W-1:0]  o_acc_q;
	logic [FULL_W-1:0] o_full_q;
	logic [CYC_W-1:0]  o_cyc_q;

	logic [CAP_W-1:0]  in_cur;
	logic [CAP_W-1:0]  in_mag;
	logic              accept;
	logic [CAP_W-1:0]  cell_ext;
	logic [CAP_W-1:0]  rem_sub;
	logic [1:0]        n_sub;
	logic              learn_ok;
	logic [SAMP_W-1:0] lsamp_inc;
	logic [CAP_W-1:0]  cyc_acc_next;
	logic [TEMP_W-1:0] t_lo;
	logic [5:0]        cold_diff;
	logic [14:0]       third_prod;
	logic [PCT_W-1:0]  cold_step;
	logic [PCT_W-1:0]  derate_pct;
	logic [DIV_W-1:0]  derate_scale;
	logic              out_free;
	logic [CAP_W-SCALE_PRE-1:0] scale_in;
	logic [SCALE_PROD_W-1:0]    scale_prod;
	logic [FULL_W-1:0]          scale_quo;

	ccse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dividend_q),
		.divisor  (div_divisor_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_cur   = CAP_W'(sample.current_sample);
	assign in_mag   = (~in_cur) + 1'b1;
	assign accept   = sample.valid && (state_q == S_IDLE);
	assign cell_ext = CAP_W'(cell_q);
	assign rem_sub  = (rem_q < mag_q) ? '0 : rem_q - mag_q;
	assign out_free = !out_valid_q || result.ready;

	// Remaining capacity over the fixed scale
	assign scale_in   = rem_q[CAP_W-1:SCALE_PRE];
	assign scale_prod = SCALE_PROD_W'(scale_in) * SCALE_PROD_W'(SCALE_RECIP);
	assign scale_quo  = FULL_W'(scale_prod >> SCALE_SHIFT);

	// Divider launches
	assign div_start = (state_q == S_DER_START) ||
		(state_q == S_SOC_START && full_q != '0);

	// Number of remaining-capacity subtractions from cell and percent tiers
	always_comb begin
		if (cell_q > CELL_LOW) begin
			if (soc_q < PCT_TIER) begin
				n_sub = 2'd2;
			end else if (cell_q < CELL_MID && soc_q > PCT_TIER) begin
				n_sub = 2'd2;
			end else begin
				n_sub = 2'd1;
			end
		end else begin
			n_sub = 2'd3;
		end
	end

	assign learn_ok     = (run_q > LEARN_RUN) && (cur_q < LEARN_CURRENT);
	assign lsamp_inc    = lsamp_q + 1'b1;
	assign cyc_acc_next = cyc_acc_q;

	// Cold derating: scale = (100 - (58 - t)/3) * 97, /3 by reciprocal
	assign t_lo       = (t1_q < t2_q) ? t1_q : t2_q;
	assign cold_diff  = 6'(TEMP_COLD - t_lo);
	assign third_prod = 15'(cold_diff) * 15'd171;
	assign cold_step  = PCT_W'(third_prod >> 9);
	assign derate_pct = PCT_FULL - cold_step;
	assign derate_scale = (t_lo < TEMP_COLD) ? DIV_W'(derate_pct) * DIV_W'(97)
		: DIV_W'(NOMINAL_FULL);

	// Sequencer, estimator state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_limit_q <= CAP_LIMIT_RST;
			cyc_thr_q   <= CYC_THR_RST;
			acc_q       <= '0;
			rem_q       <= '0;
			full_q      <= NOMINAL_FULL;
			cyc_acc_q   <= '0;
			cyc_cnt_q   <= '0;
			soc_q       <= '0;
			der_q       <= '0;
			lstart_q    <= '0;
			lsum_q      <= '0;
			lsamp_q     <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= div_start;
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_CAPACITY_LIMIT:  cap_limit_q <= cfg_wdata;
					CFG_CYCLE_THRESHOLD: cyc_thr_q   <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_cur[CAP_W-1]) begin
							state_q <= (in_mag > SMALL_CURRENT) ? S_DIS_ACC : S_CLAMP;
						end else begin
							state_q <= (in_cur > SMALL_CURRENT) ? S_CHG_ADD : S_CLAMP;
						end
					end
				end
				// Discharge: accumulator once, then tiered remaining subtractions
				S_DIS_ACC: begin
					acc_q <= (acc_q < mag_q) ? '0 : acc_q - mag_q;
					cnt_q <= n_sub;
					if (lstart_q != '0) begin
						lstart_q <= '0;
						lsum_q   <= '0;
						lsamp_q  <= '0;
					end
					state_q <= S_DIS_REM;
				end
				S_DIS_REM: begin
					rem_q <= rem_sub;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 2'd1) begin
						state_q <= S_DIS_EXTRA;
					end
				end
				S_DIS_EXTRA: begin
					if (acc_q < rem_q) begin
						rem_q <= rem_sub;
					end
					state_q <= S_CLAMP;
				end
				// Charge: accumulate with wrap
				S_CHG_ADD: begin
					if (lstart_q == '0 && soc_q < PCT_FULL) begin
						lstart_q <= acc_q;
					end
					acc_q     <= acc_q + cur_q;
					rem_q     <= rem_q + cur_q;
					cyc_acc_q <= cyc_acc_q + cur_q;
					state_q   <= S_CHG_LEARN;
				end
				S_CHG_LEARN: begin
					if (cyc_thr_q <= cyc_acc_next) begin
						cyc_acc_q <= '0;
						cyc_cnt_q <= cyc_cnt_q + 1'b1;
					end
					if (learn_ok) begin
						if (soc_q < PCT_FULL) begin
							lsum_q  <= lsum_q + cur_q;
							lsamp_q <= lsamp_inc;
							state_q <= (lsamp_inc > LEARN_COUNT) ? S_LRN_SUM : S_CLAMP;
						end else begin
							lsum_q   <= '0;
							lstart_q <= '0;
							lsamp_q  <= '0;
							state_q  <= S_FULL_CHECK;
						end
					end else begin
						lsum_q  <= lsum_q + cur_q;
						lsamp_q <= '0;
						state_q <= S_CLAMP;
					end
				end
				// Learning complete: learned total becomes remaining capacity
				S_LRN_SUM: begin
					rem_q    <= lsum_q + lstart_q;
					lsum_q   <= '0;
					lstart_q <= '0;
					lsamp_q  <= '0;
					soc_q    <= PCT_FULL;
					state_q  <= S_FULL_CHECK;
				end
				S_FULL_CHECK: begin
					if (cap_limit_q < rem_q) begin
						full_q <= NOMINAL_FULL;
						rem_q  <= cap_limit_q;
					end else begin
						full_q <= scale_quo;
					end
					state_q <= S_DER_START;
				end
				// Derated percent against temperature-scaled nominal
				S_DER_START: begin
					div_dividend_q <= DIV_W'(full_q) * DIV_W'(PCT_FULL);
					div_divisor_q  <= derate_scale;
					state_q        <= S_DER_WAIT;
				end
				S_DER_WAIT: begin
					if (div_done) begin
						der_q   <= (div_quo > DIV_W'(PCT_FULL)) ? PCT_FULL
							: div_quo[PCT_W-1:0];
						state_q <= S_CLAMP;
					end
				end
				// End of step: clamp to minimum cell, then recompute percent
				S_CLAMP: begin
					if (cell_ext <= acc_q) begin
						acc_q <= cell_ext;
					end
					if (cell_ext <= rem_q) begin
						rem_q  <= cell_ext;
						full_q <= NOMINAL_FULL;
					end
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					scr_q   <= (full_q < scale_quo) ? full_q : scale_quo;
					state_q <= S_SOC_START;
				end
				S_SOC_START: begin
					if (full_q == '0) begin
						soc_q   <= '0;
						state_q <= S_FINISH;
					end else begin
						div_dividend_q <= DIV_W'(scr_q) * DIV_W'(PCT_FULL);
						div_divisor_q  <= DIV_W'(full_q);
						state_q        <= S_SOC_WAIT;
					end
				end
				S_SOC_WAIT: begin
					if (div_done) begin
						soc_q   <= (div_quo > DIV_W'(PCT_FULL)) ? PCT_FULL
							: div_quo[PCT_W-1:0];
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						o_soc_q  <= soc_q;
						o_der_q  <= der_q;
						o_rem_q  <= rem_q;
						o_acc_q  <= acc_q;
						o_full_q <= full_q;
						o_cyc_q  <= cyc_cnt_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= in_cur;
			mag_q  <= in_mag;
			cell_q <= sample.min_cell_level;
			t1_q   <= sample.temp_first;
			t2_q   <= sample.temp_second;
			run_q  <= sample.run_time;
		end
	end

	assign sample.ready             = (state_q == S_IDLE);
	assign result.valid             = out_valid_q;
	assign result.charge_percent    = o_soc_q;
	assign result.derated_percent   = o_der_q;
	assign result.remaining_out     = o_rem_q;
	assign result.accumulator_out   = o_acc_q;
	assign result.full_capacity_out = o_full_q;
	assign result.cycles_out        = o_cyc_q;

endmodule
